@@ rtl/smpd_pkg.sv @@
`default_nettype none

package smpd_pkg;

    localparam int ACC_WIDTH_DEF = 16;
    localparam int OUT_W         = 16;
    localparam int DELTA_W       = 8;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_POLL    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] POS_FIRST  = 3'd1;
    localparam logic [2:0] POS_THIRD  = 3'd3;
    localparam logic [2:0] POS_FOURTH = 3'd4;
    localparam logic [2:0] POS_MAX    = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } smpd_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] delta_x;
        logic signed [OUT_W-1:0] delta_y;
        logic                    left_button;
        logic                    right_button;
        logic                    middle_button;
    } smpd_out_t;

endpackage

`default_nettype wire

@@ rtl/smpd_core.sv @@
`default_nettype none

module smpd_core
    import smpd_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_en,
    input  wire smpd_in_t  item,
    output smpd_out_t      report
);

    logic [2:0]                  pos_reg, pos_next;
    logic [7:0]                  byte0_reg, byte0_next;
    logic [7:0]                  byte1_reg, byte1_next;
    logic signed [ACC_WIDTH-1:0] sum_x_reg, sum_x_next;
    logic signed [ACC_WIDTH-1:0] sum_y_reg, sum_y_next;
    logic [2:0]                  btn_reg, btn_next;
    logic                        ignore_reg, ignore_next;

    logic [2:0]                  pos_eff;
    logic [2:0]                  pos_new;
    logic [DELTA_W-1:0]          dx;
    logic [DELTA_W-1:0]          dy;
    logic signed [ACC_WIDTH-1:0] add_x;
    logic signed [ACC_WIDTH-1:0] add_y;
    logic signed [ACC_WIDTH-1:0] rx;
    logic signed [ACC_WIDTH-1:0] ry;
    logic signed [OUT_W-1:0]     rpt_x;
    logic signed [OUT_W-1:0]     rpt_y;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic [DELTA_W-1:0]          d
    );
        logic [ACC_WIDTH:0] wide;
        wide = {acc[ACC_WIDTH-1], acc}
             + {{(ACC_WIDTH+1-DELTA_W){d[DELTA_W-1]}}, d};
        if (wide[ACC_WIDTH] != wide[ACC_WIDTH-1]) begin
            sat_add = wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                      : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            sat_add = wide[ACC_WIDTH-1:0];
        end
    endfunction

    // packet parsing
    assign pos_eff = item.rx_byte[6] ? 3'd0 : pos_reg;
    assign pos_new = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 3'd1;
    assign dx      = {byte0_reg[1:0], byte1_reg[5:0]};
    assign dy      = {byte0_reg[3:2], item.rx_byte[5:0]};
    assign add_x   = sat_add(sum_x_reg, dx);
    assign add_y   = sat_add(sum_y_reg, dy);

    always_comb begin
        pos_next    = pos_reg;
        byte0_next  = byte0_reg;
        byte1_next  = byte1_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        btn_next    = btn_reg;
        ignore_next = ignore_reg;
        rx          = sum_x_reg;
        ry          = sum_y_reg;
        if (ignore_reg) begin
            rx = '0;
            ry = '0;
        end
        if (item_en) begin
            case (item.opcode)
                OP_BYTE: begin
                    pos_next = pos_new;
                    if (pos_eff == 3'd0) begin
                        byte0_next = item.rx_byte;
                    end
                    if (pos_eff == 3'd1) begin
                        byte1_next = item.rx_byte;
                    end
                    if (pos_new == POS_FIRST) begin
                        btn_next[1:0] = item.rx_byte[5:4];
                    end else if (pos_new == POS_THIRD) begin
                        sum_x_next = add_x;
                        sum_y_next = add_y;
                    end else if (pos_new == POS_FOURTH) begin
                        btn_next[2] = item.rx_byte[5];
                    end
                end
                OP_POLL: begin
                    if (ignore_reg) begin
                        btn_next = '0;
                        if (sum_x_reg != '0 || sum_y_reg != '0) begin
                            ignore_next = 1'b0;
                        end
                    end
                    sum_x_next = '0;
                    sum_y_next = '0;
                end
                OP_RESTART: begin
                    pos_next    = '0;
                    byte0_next  = '0;
                    byte1_next  = '0;
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    ignore_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // fit the accumulators into the report width
    if (ACC_WIDTH > OUT_W) begin : g_sat
        localparam logic signed [ACC_WIDTH-1:0] OMAX =
            {{(ACC_WIDTH-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
        localparam logic signed [ACC_WIDTH-1:0] OMIN = ~OMAX;
        always_comb begin
            if (rx > OMAX) begin
                rpt_x = {1'b0, {(OUT_W-1){1'b1}}};
            end else if (rx < OMIN) begin
                rpt_x = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                rpt_x = rx[OUT_W-1:0];
            end
            if (ry > OMAX) begin
                rpt_y = {1'b0, {(OUT_W-1){1'b1}}};
            end else if (ry < OMIN) begin
                rpt_y = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                rpt_y = ry[OUT_W-1:0];
            end
        end
    end else if (ACC_WIDTH == OUT_W) begin : g_eq
        assign rpt_x = rx;
        assign rpt_y = ry;
    end else begin : g_ext
        assign rpt_x = {{(OUT_W-ACC_WIDTH){rx[ACC_WIDTH-1]}}, rx};
        assign rpt_y = {{(OUT_W-ACC_WIDTH){ry[ACC_WIDTH-1]}}, ry};
    end

    assign report.delta_x       = rpt_x;
    assign report.delta_y       = rpt_y;
    assign report.left_button   = ignore_reg ? 1'b0 : btn_reg[1];
    assign report.right_button  = ignore_reg ? 1'b0 : btn_reg[0];
    assign report.middle_button = ignore_reg ? 1'b0 : btn_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            byte0_reg  <= '0;
            byte1_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            btn_reg    <= '0;
            ignore_reg <= 1'b1;
        end else begin
            pos_reg    <= pos_next;
            byte0_reg  <= byte0_next;
            byte1_reg  <= byte1_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            btn_reg    <= btn_next;
            ignore_reg <= ignore_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/serial_mouse_packet_decoder_top.sv @@
// channel   ports                     payload
// input     s_valid s_ready s_data    smpd_in_t  (opcode, rx_byte)
// result    m_valid m_ready m_data    smpd_out_t (deltas, buttons)
//
// one beat per cycle in, unless a poll beat waits on a stalled report
// input beats are registered in in_reg; a poll beat's report is then registered in out_reg
// only poll beats give a report; other beats give none
// aresetn clears parser state, accumulators and buttons and arms ignore mode
// a stalled report holds a waiting poll beat, and the beats behind it wait too
`default_nettype none

module serial_mouse_packet_decoder_top
    import smpd_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire smpd_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output smpd_out_t      m_data
);

    smpd_in_t  in_reg;
    logic      in_valid_reg, in_valid_next;
    smpd_out_t out_reg;
    logic      out_valid_reg, out_valid_next;
    smpd_out_t report;
    logic      is_poll;
    logic      out_free;
    logic      advance;
    logic      load;

    assign is_poll  = (in_reg.opcode == OP_POLL);
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!is_poll || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign load     = s_valid && s_ready;

    smpd_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (advance),
        .item    (in_reg),
        .report  (report)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && is_poll) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_reg <= s_data;
        end
        if (advance && is_poll) begin
            out_reg <= report;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
